// ===== hdl/psfl_pkg.sv =====
package psfl_pkg;

    localparam int ADDR_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Command codes.
    localparam cmd_t CMD_FREE_PAGE  = 2'd0;
    localparam cmd_t CMD_ALLOC_PAGE = 2'd1;
    localparam cmd_t CMD_FREE_SLAB  = 2'd2;
    localparam cmd_t CMD_ALLOC_SLAB = 2'd3;

    // Status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_PAGE  = 2'd1;
    localparam status_t ST_NO_MEMORY = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Configuration register indexes.
    localparam cfg_idx_t REG_KERNEL_END = 1'b0;
    localparam cfg_idx_t REG_MEMORY_TOP = 1'b1;

    localparam addr_t KERNEL_END_RESET = 32'h8040_0000;
    localparam addr_t MEMORY_TOP_RESET = 32'h8E00_0000;

    localparam int DEF_PAGE_DEPTH = 65536;
    localparam int DEF_SLAB_DEPTH = 1024;
    localparam int DEF_PAGE_BYTES = 4096;
    localparam int DEF_SLAB_BYTES = 32;

endpackage

// ===== hdl/page_and_slab_free_list_allocator.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_command, s_address
// m_        out        m_valid/m_ready    m_status, m_granted_address, m_free_pages, m_free_slabs
// cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata
//
// For each command, the transfer cycle reads the top of both stacks, and the EXEC state
// then pushes or pops and loads the result register once the output is free.
// A slab allocation from an empty slab pool first carves a popped page into slabs in FILL
// (PAGE_BYTES / SLAB_BYTES, capped at SLAB_DEPTH; 128 slabs by default).
// Reset clears both counts; the stack memories need no clearing pass.
// While a result waits for m_ready, the next command is taken but not completed.
module page_and_slab_free_list_allocator #(
    parameter int PAGE_DEPTH = psfl_pkg::DEF_PAGE_DEPTH,
    parameter int SLAB_DEPTH = psfl_pkg::DEF_SLAB_DEPTH,
    parameter int PAGE_BYTES = psfl_pkg::DEF_PAGE_BYTES,
    parameter int SLAB_BYTES = psfl_pkg::DEF_SLAB_BYTES,
    localparam int PCW = $clog2(PAGE_DEPTH + 1),
    localparam int SCW = $clog2(SLAB_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  psfl_pkg::cfg_idx_t cfg_addr,
    input  psfl_pkg::addr_t    cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  psfl_pkg::cmd_t     s_command,
    input  psfl_pkg::addr_t    s_address,
    output logic               m_valid,
    input  logic               m_ready,
    output psfl_pkg::status_t  m_status,
    output psfl_pkg::addr_t    m_granted_address,
    output logic [PCW-1:0]     m_free_pages,
    output logic [SCW-1:0]     m_free_slabs
);

    import psfl_pkg::*;

    localparam int PAW = $clog2(PAGE_DEPTH);
    localparam int SAW = $clog2(SLAB_DEPTH);
    localparam int PEW = ADDR_W - $clog2(PAGE_BYTES);
    localparam int SEW = ADDR_W - $clog2(SLAB_BYTES);

    addr_t kernel_end_reg;
    addr_t memory_top_reg;

    logic           page_wr_en;
    logic [PAW-1:0] page_wr_addr;
    logic [PEW-1:0] page_wr_data;
    logic           page_rd_en;
    logic [PAW-1:0] page_rd_addr;
    logic [PEW-1:0] page_rd_data;
    logic           slab_wr_en;
    logic [SAW-1:0] slab_wr_addr;
    logic [SEW-1:0] slab_wr_data;
    logic           slab_rd_en;
    logic [SAW-1:0] slab_rd_addr;
    logic [SEW-1:0] slab_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_end_reg <= KERNEL_END_RESET;
            memory_top_reg <= MEMORY_TOP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KERNEL_END: kernel_end_reg <= cfg_wdata;
                REG_MEMORY_TOP: memory_top_reg <= cfg_wdata;
                default: begin
                    kernel_end_reg <= kernel_end_reg;
                end
            endcase
        end
    end

    psfl_ctrl #(
        .PAGE_DEPTH(PAGE_DEPTH),
        .SLAB_DEPTH(SLAB_DEPTH),
        .PAGE_BYTES(PAGE_BYTES),
        .SLAB_BYTES(SLAB_BYTES)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .kernel_end        (kernel_end_reg),
        .memory_top        (memory_top_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .m_free_pages      (m_free_pages),
        .m_free_slabs      (m_free_slabs),
        .page_wr_en        (page_wr_en),
        .page_wr_addr      (page_wr_addr),
        .page_wr_data      (page_wr_data),
        .page_rd_en        (page_rd_en),
        .page_rd_addr      (page_rd_addr),
        .page_rd_data      (page_rd_data),
        .slab_wr_en        (slab_wr_en),
        .slab_wr_addr      (slab_wr_addr),
        .slab_wr_data      (slab_wr_data),
        .slab_rd_en        (slab_rd_en),
        .slab_rd_addr      (slab_rd_addr),
        .slab_rd_data      (slab_rd_data)
    );

    psfl_ram #(
        .DEPTH(PAGE_DEPTH),
        .WIDTH(PEW)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (page_wr_en),
        .wr_addr (page_wr_addr),
        .wr_data (page_wr_data),
        .rd_en   (page_rd_en),
        .rd_addr (page_rd_addr),
        .rd_data (page_rd_data)
    );

    psfl_ram #(
        .DEPTH(SLAB_DEPTH),
        .WIDTH(SEW)
    ) u_slab_ram (
        .aclk    (aclk),
        .wr_en   (slab_wr_en),
        .wr_addr (slab_wr_addr),
        .wr_data (slab_wr_data),
        .rd_en   (slab_rd_en),
        .rd_addr (slab_rd_addr),
        .rd_data (slab_rd_data)
    );

endmodule

// ===== hdl/psfl_ram.sv =====
module psfl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 27,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/psfl_ctrl.sv =====
module psfl_ctrl #(
    parameter int PAGE_DEPTH = 65536,
    parameter int SLAB_DEPTH = 1024,
    parameter int PAGE_BYTES = 4096,
    parameter int SLAB_BYTES = 32,
    localparam int PAW = $clog2(PAGE_DEPTH),
    localparam int SAW = $clog2(SLAB_DEPTH),
    localparam int PCW = $clog2(PAGE_DEPTH + 1),
    localparam int SCW = $clog2(SLAB_DEPTH + 1),
    localparam int PEW = psfl_pkg::ADDR_W - $clog2(PAGE_BYTES),
    localparam int SEW = psfl_pkg::ADDR_W - $clog2(SLAB_BYTES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  psfl_pkg::addr_t   kernel_end,
    input  psfl_pkg::addr_t   memory_top,
    input  logic              s_valid,
    output logic              s_ready,
    input  psfl_pkg::cmd_t    s_command,
    input  psfl_pkg::addr_t   s_address,
    output logic              m_valid,
    input  logic              m_ready,
    output psfl_pkg::status_t m_status,
    output psfl_pkg::addr_t   m_granted_address,
    output logic [PCW-1:0]    m_free_pages,
    output logic [SCW-1:0]    m_free_slabs,
    output logic              page_wr_en,
    output logic [PAW-1:0]    page_wr_addr,
    output logic [PEW-1:0]    page_wr_data,
    output logic              page_rd_en,
    output logic [PAW-1:0]    page_rd_addr,
    input  logic [PEW-1:0]    page_rd_data,
    output logic              slab_wr_en,
    output logic [SAW-1:0]    slab_wr_addr,
    output logic [SEW-1:0]    slab_wr_data,
    output logic              slab_rd_en,
    output logic [SAW-1:0]    slab_rd_addr,
    input  logic [SEW-1:0]    slab_rd_data
);

    import psfl_pkg::*;

    localparam int PBL        = $clog2(PAGE_BYTES);
    localparam int SBL        = $clog2(SLAB_BYTES);
    localparam int CARVE_RAW  = PAGE_BYTES / SLAB_BYTES;
    localparam int CARVE_N    = (CARVE_RAW > SLAB_DEPTH) ? SLAB_DEPTH : CARVE_RAW;
    localparam int CARVE_LAST = (CARVE_N > 0) ? CARVE_N - 1 : 0;
    localparam logic [ADDR_W-1:0] LAST_OFF = ADDR_W'(CARVE_LAST * SLAB_BYTES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]     state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    addr_t          addr_reg, addr_next;
    logic [PCW-1:0] page_count_reg, page_count_next;
    logic [SCW-1:0] slab_count_reg, slab_count_next;
    logic [SAW-1:0] fill_idx_reg, fill_idx_next;
    addr_t          base_reg, base_next;
    logic           m_valid_reg, m_valid_next;
    status_t        m_status_reg, m_status_next;
    addr_t          m_grant_reg, m_grant_next;
    logic [PCW-1:0] m_pages_reg, m_pages_next;
    logic [SCW-1:0] m_slabs_reg, m_slabs_next;

    logic           accept;
    logic           out_free;
    logic           bad_page;
    logic           emit;
    status_t        res_status;
    addr_t          res_grant;
    logic [PCW-1:0] page_dec;
    logic [SCW-1:0] slab_dec;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign page_dec = page_count_reg - 1'b1;
    assign slab_dec = slab_count_reg - 1'b1;

    // Pops read the top entry in the cycle the command is taken.
    assign page_rd_en   = accept;
    assign page_rd_addr = page_dec[PAW-1:0];
    assign slab_rd_en   = accept;
    assign slab_rd_addr = slab_dec[SAW-1:0];

    assign bad_page = (addr_reg[PBL-1:0] != '0) || (addr_reg < kernel_end) ||
                      (addr_reg >= memory_top);

    assign page_wr_addr = page_count_reg[PAW-1:0];
    assign page_wr_data = addr_reg[ADDR_W-1:PBL];

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        page_count_next = page_count_reg;
        slab_count_next = slab_count_reg;
        fill_idx_next   = fill_idx_reg;
        base_next       = base_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_grant_next    = m_grant_reg;
        m_pages_next    = m_pages_reg;
        m_slabs_next    = m_slabs_reg;
        emit            = 1'b0;
        res_status      = ST_OK;
        res_grant       = '0;
        page_wr_en      = 1'b0;
        slab_wr_en      = 1'b0;
        slab_wr_addr    = slab_count_reg[SAW-1:0];
        slab_wr_data    = addr_reg[ADDR_W-1:SBL];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_command;
                    addr_next  = s_address;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    emit = 1'b1;
                    unique case (cmd_reg)
                        CMD_FREE_PAGE: begin
                            if (bad_page) begin
                                res_status = ST_BAD_PAGE;
                            end else if (page_count_reg == PCW'(PAGE_DEPTH)) begin
                                res_status = ST_FULL;
                            end else begin
                                page_wr_en      = 1'b1;
                                page_count_next = page_count_reg + 1'b1;
                            end
                        end
                        CMD_ALLOC_PAGE: begin
                            if (page_count_reg == '0) begin
                                res_status = ST_NO_MEMORY;
                            end else begin
                                page_count_next = page_dec;
                                res_grant       = {page_rd_data, {PBL{1'b0}}};
                            end
                        end
                        CMD_FREE_SLAB: begin
                            if (slab_count_reg == SCW'(SLAB_DEPTH)) begin
                                res_status = ST_FULL;
                            end else begin
                                slab_wr_en      = 1'b1;
                                slab_count_next = slab_count_reg + 1'b1;
                            end
                        end
                        CMD_ALLOC_SLAB: begin
                            if (slab_count_reg != '0) begin
                                slab_count_next = slab_dec;
                                res_grant       = {slab_rd_data, {SBL{1'b0}}};
                            end else if (page_count_reg == '0) begin
                                res_status = ST_NO_MEMORY;
                            end else if (CARVE_N == 0) begin
                                // The page is consumed but yields no slab.
                                page_count_next = page_dec;
                                res_status      = ST_NO_MEMORY;
                            end else begin
                                page_count_next = page_dec;
                                base_next       = {page_rd_data, {PBL{1'b0}}};
                                fill_idx_next   = '0;
                                emit            = 1'b0;
                                state_next      = S_FILL;
                            end
                        end
                        default: begin
                            res_status = ST_OK;
                        end
                    endcase
                    if (emit) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FILL: begin
                // Carve the popped page into slabs, lowest address first. The
                // last slab is granted at once, so its entry is left above the count.
                slab_wr_en   = 1'b1;
                slab_wr_addr = fill_idx_reg;
                slab_wr_data = base_reg[ADDR_W-1:SBL] + SEW'(fill_idx_reg);
                if (fill_idx_reg == SAW'(CARVE_LAST)) begin
                    if (out_free) begin
                        emit            = 1'b1;
                        res_grant       = base_reg + LAST_OFF;
                        slab_count_next = SCW'(CARVE_LAST);
                        state_next      = S_IDLE;
                    end
                end else begin
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status;
            m_grant_next  = res_grant;
            m_pages_next  = page_count_next;
            m_slabs_next  = slab_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            page_count_reg <= '0;
            slab_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            slab_count_reg <= slab_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        fill_idx_reg <= fill_idx_next;
        base_reg     <= base_next;
        m_status_reg <= m_status_next;
        m_grant_reg  <= m_grant_next;
        m_pages_reg  <= m_pages_next;
        m_slabs_reg  <= m_slabs_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_grant_reg;
    assign m_free_pages      = m_pages_reg;
    assign m_free_slabs      = m_slabs_reg;

endmodule

// ===== tb/free_list_checker.sv =====
`timescale 1ns / 100ps

module free_list_checker
    import psfl_pkg::*;
#(
    parameter int PCW = $clog2(DEF_PAGE_DEPTH + 1),
    parameter int SCW = $clog2(DEF_SLAB_DEPTH + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  cfg_idx_t       cfg_addr,
    input  addr_t          cfg_wdata,
    input  logic           s_valid,
    input  logic           s_ready,
    input  cmd_t           s_command,
    input  addr_t          s_address,
    input  logic           m_valid,
    input  logic           m_ready,
    input  status_t        m_status,
    input  addr_t          m_granted_address,
    input  logic [PCW-1:0] m_free_pages,
    input  logic [SCW-1:0] m_free_slabs,
    output int             mismatches,
    output int             outstanding,
    output int             checked,
    output int             refused,
    output int             refills
);

    // A page is carved into this many slabs, never more than the slab stack holds.
    localparam int CARVE_COUNT = (DEF_PAGE_BYTES / DEF_SLAB_BYTES > DEF_SLAB_DEPTH) ?
                                 DEF_SLAB_DEPTH : DEF_PAGE_BYTES / DEF_SLAB_BYTES;

    typedef struct packed {
        status_t        status;
        addr_t          grant;
        logic [PCW-1:0] pages;
        logic [SCW-1:0] slabs;
    } outcome_t;

    addr_t       page_frames [DEF_PAGE_DEPTH];
    addr_t       slab_slots [DEF_SLAB_DEPTH];
    int unsigned page_top;
    int unsigned slab_top;
    addr_t       kernel_end;
    addr_t       memory_top;
    outcome_t    pending_outcomes [$];

    task automatic report_mismatch(input string what);
        if (mismatches < 25) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic bit take_page(output addr_t base);
        base = '0;
        if (page_top == 0) begin
            return 1'b0;
        end
        page_top--;
        base = addr_t'(page_frames[page_top] * DEF_PAGE_BYTES);
        return 1'b1;
    endfunction

    function automatic bit stack_slab(input addr_t addr);
        if (slab_top >= DEF_SLAB_DEPTH) begin
            return 1'b0;
        end
        slab_slots[slab_top] = addr / DEF_SLAB_BYTES;
        slab_top++;
        return 1'b1;
    endfunction

    function automatic outcome_t apply_command(input cmd_t cmd, input addr_t addr);
        outcome_t res;
        addr_t    base;
        res.status = ST_OK;
        res.grant  = '0;
        case (cmd)
            CMD_FREE_PAGE: begin
                if (addr % DEF_PAGE_BYTES != 0 || addr < kernel_end || addr >= memory_top) begin
                    res.status = ST_BAD_PAGE;
                end else if (page_top >= DEF_PAGE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    page_frames[page_top] = addr / DEF_PAGE_BYTES;
                    page_top++;
                end
            end
            CMD_ALLOC_PAGE: begin
                if (take_page(base)) begin
                    res.grant = base;
                end else begin
                    res.status = ST_NO_MEMORY;
                end
            end
            CMD_FREE_SLAB: begin
                if (!stack_slab(addr)) begin
                    res.status = ST_FULL;
                end
            end
            CMD_ALLOC_SLAB: begin
                // An empty slab pool is refilled from one page, lowest slab pushed first.
                if (slab_top == 0 && take_page(base)) begin
                    for (int i = 0; i < CARVE_COUNT; i++) begin
                        void'(stack_slab(base + addr_t'(i * DEF_SLAB_BYTES)));
                    end
                    refills++;
                end
                if (slab_top == 0) begin
                    res.status = ST_NO_MEMORY;
                end else begin
                    slab_top--;
                    res.grant = addr_t'(slab_slots[slab_top] * DEF_SLAB_BYTES);
                end
            end
        endcase
        res.pages = PCW'(page_top);
        res.slabs = SCW'(slab_top);
        return res;
    endfunction

    always @(posedge aclk) begin : track
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            page_top   = 0;
            slab_top   = 0;
            kernel_end = KERNEL_END_RESET;
            memory_top = MEMORY_TOP_RESET;
            mismatches = 0;
            checked    = 0;
            refused    = 0;
            refills    = 0;
            pending_outcomes.delete();
        end else begin
            // Results are retired before new commands so a transfer on both sides
            // at one edge is handled in order.
            if (m_valid && m_ready) begin
                got.status = m_status;
                got.grant  = m_granted_address;
                got.pages  = m_free_pages;
                got.slabs  = m_free_slabs;
                checked++;
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no command pending",
                                              checked));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (want.status != ST_OK) begin
                        refused++;
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                                  checked, got.status, want.status));
                    end
                    if (got.grant !== want.grant) begin
                        report_mismatch($sformatf("result %0d: granted %h, expected %h",
                                                  checked, got.grant, want.grant));
                    end
                    if (got.pages !== want.pages) begin
                        report_mismatch($sformatf("result %0d: free pages %0d, expected %0d",
                                                  checked, got.pages, want.pages));
                    end
                    if (got.slabs !== want.slabs) begin
                        report_mismatch($sformatf("result %0d: free slabs %0d, expected %0d",
                                                  checked, got.slabs, want.slabs));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_KERNEL_END: kernel_end = cfg_wdata;
                    REG_MEMORY_TOP: memory_top = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pending_outcomes.push_back(apply_command(s_command, s_address));
            end
        end
        outstanding <= pending_outcomes.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import psfl_pkg::*;

    localparam int PCW             = $clog2(DEF_PAGE_DEPTH + 1);
    localparam int SCW             = $clog2(DEF_SLAB_DEPTH + 1);
    localparam int PAGE_SHIFT      = $clog2(DEF_PAGE_BYTES);
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int BURST_ITEMS     = 12;
    localparam int CYCLE_LIMIT     = 2_000_000;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           cfg_wr_en = 1'b0;
    cfg_idx_t       cfg_addr = REG_KERNEL_END;
    addr_t          cfg_wdata = '0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    cmd_t           s_command = CMD_FREE_PAGE;
    addr_t          s_address = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    status_t        m_status;
    addr_t          m_granted_address;
    logic [PCW-1:0] m_free_pages;
    logic [SCW-1:0] m_free_slabs;

    int    mismatches;
    int    outstanding;
    int    checked;
    int    refused;
    int    refills;
    int    sent = 0;
    int    cycles = 0;
    int    ready_left = 0;
    logic  rx_steady = 1'b0;
    addr_t kernel_end = KERNEL_END_RESET;
    addr_t memory_top = MEMORY_TOP_RESET;

    page_and_slab_free_list_allocator dut (.*);

    free_list_checker watcher (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending", cycles, outstanding);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left <= 0;
        end else if (rx_steady) begin
            m_ready    <= 1'b1;
            ready_left <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 10);
        end else begin
            m_ready    <= 1'b0;
            ready_left <= pick_gap();
        end
    end

    // An aligned page inside the current window, or any address when the window is empty.
    function automatic addr_t legal_page();
        longint lo;
        longint hi;
        lo = (longint'(kernel_end) + DEF_PAGE_BYTES - 1) >> PAGE_SHIFT;
        hi = (longint'(memory_top) + DEF_PAGE_BYTES - 1) >> PAGE_SHIFT;
        if (hi <= lo) return $urandom();
        return addr_t'($urandom_range(32'(hi - 1), 32'(lo)) << PAGE_SHIFT);
    endfunction

    function automatic addr_t bad_page();
        case ($urandom_range(0, 3))
            0: return legal_page() | addr_t'($urandom_range(1, DEF_PAGE_BYTES - 1));
            1: return kernel_end - addr_t'($urandom_range(1, 8) << PAGE_SHIFT);
            2: return (memory_top + addr_t'(DEF_PAGE_BYTES - 1)) & ~addr_t'(DEF_PAGE_BYTES - 1);
            default: return $urandom();
        endcase
    endfunction

    task automatic issue(input cmd_t cmd, input addr_t addr);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic pause(input int idle_cycles);
        if (idle_cycles > 0) begin
            s_valid <= 1'b0;
            repeat (idle_cycles) @(posedge aclk);
        end
    endtask

    task automatic drive_item(input cmd_t cmd, input addr_t addr);
        issue(cmd, addr);
        pause(pick_gap());
    endtask

    // Hold off new commands until every result has been transferred.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_limits(input addr_t kend, input addr_t mtop);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_KERNEL_END;
        cfg_wdata <= kend;
        @(posedge aclk);
        cfg_addr  <= REG_MEMORY_TOP;
        cfg_wdata <= mtop;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        kernel_end = kend;
        memory_top = mtop;
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            issue(CMD_FREE_PAGE, legal_page());
        end else if (pick < 33) begin
            issue(CMD_FREE_PAGE, bad_page());
        end else if (pick < 50) begin
            issue(CMD_ALLOC_PAGE, $urandom());
        end else if (pick < 70) begin
            issue(CMD_FREE_SLAB, $urandom());
        end else begin
            issue(CMD_ALLOC_SLAB, $urandom());
        end
    endtask

    initial begin
        addr_t kend_new;
        addr_t mtop_new;
        addr_t other;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty pools, window edges, a refill, an unaligned slab and a drained page pool.
        drive_item(CMD_ALLOC_PAGE, '0);
        drive_item(CMD_ALLOC_SLAB, '1);
        drive_item(CMD_FREE_PAGE, KERNEL_END_RESET);
        drive_item(CMD_FREE_PAGE, MEMORY_TOP_RESET - addr_t'(DEF_PAGE_BYTES));
        drive_item(CMD_FREE_PAGE, MEMORY_TOP_RESET);
        drive_item(CMD_FREE_PAGE, KERNEL_END_RESET - addr_t'(DEF_PAGE_BYTES));
        drive_item(CMD_FREE_PAGE, KERNEL_END_RESET + 32'h1);
        drive_item(CMD_FREE_PAGE, KERNEL_END_RESET + 32'h800);
        drive_item(CMD_FREE_PAGE, '0);
        drive_item(CMD_FREE_PAGE, '1);
        drive_item(CMD_ALLOC_SLAB, '0);
        drive_item(CMD_ALLOC_SLAB, '1);
        drive_item(CMD_FREE_SLAB, 32'h1234_567F);
        drive_item(CMD_ALLOC_SLAB, '0);
        drive_item(CMD_FREE_SLAB, '1);
        drive_item(CMD_FREE_SLAB, '0);
        drive_item(CMD_ALLOC_SLAB, '0);
        drive_item(CMD_ALLOC_SLAB, '0);
        drive_item(CMD_ALLOC_PAGE, '1);
        drive_item(CMD_ALLOC_PAGE, '0);
        drive_item(CMD_ALLOC_SLAB, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    kend_new = KERNEL_END_RESET;
                    mtop_new = MEMORY_TOP_RESET;
                end
                1: begin
                    kend_new = '0;
                    mtop_new = '1;
                end
                2: begin
                    kend_new = '0;
                    mtop_new = '0;
                end
                3: begin
                    kend_new = '1;
                    mtop_new = '1;
                end
                4: begin
                    kend_new = $urandom() & ~addr_t'(DEF_PAGE_BYTES - 1);
                    mtop_new = kend_new + addr_t'($urandom_range(1, 64) << PAGE_SHIFT);
                end
                5: begin
                    // Window upside down: every page free is refused.
                    kend_new = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
                    mtop_new = $urandom_range(32'h7FFF_FFFF, 0);
                end
                6: begin
                    kend_new = 32'h0000_1801;
                    mtop_new = 32'h0010_0800;
                end
                default: begin
                    kend_new = $urandom();
                    other    = $urandom();
                    if (other < kend_new) begin
                        mtop_new = kend_new;
                        kend_new = other;
                    end else begin
                        mtop_new = other;
                    end
                end
            endcase
            set_limits(kend_new, mtop_new);
            rx_steady <= 1'b1;
            repeat (BURST_ITEMS) random_item();
            rx_steady <= 1'b0;
            repeat (ITEMS_PER_PHASE - BURST_ITEMS) begin
                random_item();
                if ($urandom_range(0, 149) == 0) begin
                    drain();
                end else begin
                    pause(pick_gap());
                end
            end
        end

        // Overflow the slab stack, then take a few back.
        drain();
        rx_steady <= 1'b1;
        repeat (DEF_SLAB_DEPTH + 6) issue(CMD_FREE_SLAB, $urandom());
        rx_steady <= 1'b0;
        repeat (4) drive_item(CMD_ALLOC_SLAB, $urandom());

        // Widest window, with pages at both ends of the address space.
        drain();
        set_limits('0, '1);
        drive_item(CMD_FREE_PAGE, 32'hFFFF_F000);
        drive_item(CMD_ALLOC_PAGE, '0);
        drive_item(CMD_ALLOC_PAGE, '0);
        drive_item(CMD_FREE_PAGE, 32'hFFFF_F000);
        drive_item(CMD_FREE_PAGE, '0);
        drive_item(CMD_ALLOC_SLAB, '0);
        drive_item(CMD_ALLOC_SLAB, '1);

        drain();
        repeat (16) @(posedge aclk);

        $display("Sent %0d commands over %0d address windows, with the slab stack driven full.",
                 sent, PHASES + 1);
        $display("Checked %0d results: %0d refused, %0d slab pool refills from pages.",
                 checked, refused, refills);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
